FILE: src/dtfp_pkg.sv
package dtfp_pkg;

  localparam int FRAC_DIGITS_DEF = 9;
  localparam int FRAC_BITS       = 32;
  localparam int INT_BITS        = 31;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] SEP_RESET  = 8'h2E;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               overflow;
    logic               separator_seen;
  } out_item_t;

  typedef struct packed {
    logic parse;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic frac_zero;
    logic out_free;
  } status_t;

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

FILE: src/dtfp_ctrl.sv
module dtfp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  dtfp_pkg::status_t status,
  output dtfp_pkg::cmd_t    cmd
);
  import dtfp_pkg::*;

  localparam int IW = $clog2(FRAC_BITS);

  localparam logic [1:0] S_PARSE = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;

  logic [1:0]    state, state_next;
  logic [IW-1:0] iter, iter_next;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_PARSE: begin
        in_ready  = 1'b1;
        cmd.parse = in_valid;
        if (in_valid && in_last) begin
          state_next = S_DIV;
          iter_next  = '0;
        end
      end
      S_DIV: begin
        // no fraction digits: quotient stays zero
        if (status.frac_zero) begin
          state_next = S_LOAD;
        end else begin
          cmd.step  = 1'b1;
          iter_next = iter + 1'b1;
          if (iter == IW'(FRAC_BITS - 1)) state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_PARSE;
        end
      end
      default: state_next = S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PARSE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

endmodule

FILE: src/dtfp_datapath.sv
module dtfp_datapath #(
  parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  dtfp_pkg::in_item_t  in_item,
  input  dtfp_pkg::cmd_t      cmd,
  output dtfp_pkg::status_t   status,
  output logic                out_valid,
  input  logic                out_ready,
  output dtfp_pkg::out_item_t out_item
);
  import dtfp_pkg::*;

  localparam int FW = $clog2(pow10(5'(FRAC_DIGITS)));
  localparam int CW = $clog2(FRAC_DIGITS + 1);

  logic [7:0]          separator;
  logic                signed_ph, signed_ph_next;
  logic                closed, closed_next;
  logic                negative, negative_next;
  logic [INT_BITS-1:0] int_accum, int_accum_next;
  logic                int_done, int_done_next;
  logic                sep_found, sep_found_next;
  logic [FW-1:0]       frac_accum, frac_accum_next;
  logic [CW-1:0]       frac_count, frac_count_next;
  logic                sat, sat_next;
  logic [FRAC_BITS-1:0] quot;

  logic [7:0]          c;
  logic                is_digit;
  logic [3:0]          digit;
  logic [INT_BITS+3:0] int_t;
  logic [FW+3:0]       frac_t;
  logic [FW:0]         divisor, rem_shift;
  logic [63:0]         mag;

  assign c        = in_item.text_byte;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign digit    = 4'(c - CHAR_ZERO);
  assign int_t    = {int_accum, 3'b000} + {2'b00, int_accum, 1'b0} + (INT_BITS+4)'(digit);
  assign frac_t   = {frac_accum, 3'b000} + {2'b00, frac_accum, 1'b0} + (FW+4)'(digit);

  // next parse state for the accepted byte
  always_comb begin
    signed_ph_next  = signed_ph;
    closed_next     = closed;
    negative_next   = negative;
    int_accum_next  = int_accum;
    int_done_next   = int_done;
    sep_found_next  = sep_found;
    frac_accum_next = frac_accum;
    frac_count_next = frac_count;
    sat_next        = sat;

    if (!int_done) begin
      if (!signed_ph && c == CHAR_SPACE) begin
        // skip leading space
      end else if (!signed_ph && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
        signed_ph_next = 1'b1;
        negative_next  = (c == CHAR_MINUS);
      end else begin
        signed_ph_next = 1'b1;
        if (!is_digit) begin
          int_done_next = 1'b1;
        end else if (!sat) begin
          if (int_t > (INT_BITS+4)'({INT_BITS{1'b1}})) begin
            int_accum_next = '1;
            sat_next       = 1'b1;
          end else begin
            int_accum_next = int_t[INT_BITS-1:0];
          end
        end
      end
    end

    if (!sep_found) begin
      if (c == separator) sep_found_next = 1'b1;
    end else if (!closed) begin
      if (!is_digit) begin
        closed_next = 1'b1;
      end else if (frac_count < CW'(FRAC_DIGITS)) begin
        frac_accum_next = frac_t[FW-1:0];
        frac_count_next = frac_count + 1'b1;
      end
    end
  end

  // restoring division step; the fraction register holds the remainder
  assign divisor   = (FW+1)'(pow10(5'(frac_count)));
  assign rem_shift = {frac_accum, 1'b0};

  assign mag = negative ? (64'd0 - {1'b0, int_accum, quot}) : {1'b0, int_accum, quot};

  assign status.frac_zero = (frac_count == '0);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= SEP_RESET;
    end else if (cfg_write) begin
      separator <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      signed_ph  <= 1'b0;
      closed     <= 1'b0;
      negative   <= 1'b0;
      int_accum  <= '0;
      int_done   <= 1'b0;
      sep_found  <= 1'b0;
      frac_accum <= '0;
      frac_count <= '0;
      sat        <= 1'b0;
      quot       <= '0;
    end else if (cmd.parse) begin
      signed_ph  <= signed_ph_next;
      closed     <= closed_next;
      negative   <= negative_next;
      int_accum  <= int_accum_next;
      int_done   <= int_done_next;
      sep_found  <= sep_found_next;
      frac_accum <= frac_accum_next;
      frac_count <= frac_count_next;
      sat        <= sat_next;
    end else if (cmd.step) begin
      if (rem_shift >= divisor) begin
        frac_accum <= FW'(rem_shift - divisor);
        quot       <= {quot[FRAC_BITS-2:0], 1'b1};
      end else begin
        frac_accum <= rem_shift[FW-1:0];
        quot       <= {quot[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.value          <= mag;
      out_item.overflow       <= sat;
      out_item.separator_seen <= sep_found;
    end
  end

endmodule

FILE: src/decimal_text_to_fixed_point.sv
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_write            cfg_data (separator byte)
// in       in         in_valid / in_ready  in_item: text_byte, last_byte
// out      out        out_valid / out_ready out_item: value (Q31.32), overflow,
//                                           separator_seen
// A byte that is not last is taken as soon as it is offered. After a last byte the
// fraction is converted by a restoring divider, one quotient bit a cycle, until the
// quotient is complete (skipped when no fraction digit was taken), then the output
// register is loaded once it is free; in_ready stays low through both.
// Reset puts the separator to '.' and clears the parser; no clearing pass.
// The output register holds a finished item, so the next string streams in
// while out_ready is low; only a second finished item waits for it.
module decimal_text_to_fixed_point #(
  parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtfp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dtfp_pkg::out_item_t out_item
);
  import dtfp_pkg::*;

  cmd_t    cmd;
  status_t status;

  dtfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_item.last_byte),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dtfp_datapath #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfp_pkg::*;

  localparam int FRAC_LIMIT   = FRAC_DIGITS_DEF;
  localparam int PHASE_CHARS  = 95;
  localparam int SETTLE       = 40;
  localparam int HOLD_AT      = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTINGS_NUM = 7;
  localparam logic [7:0] SEPARATORS [SETTINGS_NUM] =
    '{8'h2C, 8'h00, 8'hFF, 8'h35, CHAR_MINUS, CHAR_SPACE, SEP_RESET};

  typedef logic [7:0] text_q_t [$];

  // Tracks the parser state per accepted character and holds the numbers
  // that must come out, oldest first.
  class number_scoreboard;
    logic [7:0]  separator;
    bit          lead_done, negative, int_closed, sep_seen, frac_closed, saturated;
    logic [31:0] int_part;
    logic [59:0] frac_digits;
    logic [4:0]  frac_count;
    out_item_t   due_numbers [$];
    int          errors, chars, checked, saturations;

    function new();
      separator = SEP_RESET;
      clear();
    endfunction

    function void clear();
      lead_done   = 1'b0;
      negative    = 1'b0;
      int_closed  = 1'b0;
      sep_seen    = 1'b0;
      frac_closed = 1'b0;
      saturated   = 1'b0;
      int_part    = '0;
      frac_digits = '0;
      frac_count  = '0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function void take_char(in_item_t it);
      logic [7:0]  c;
      logic [63:0] wide;
      logic [63:0] scale;
      logic [95:0] num;
      logic [31:0] q;
      logic [63:0] mag;
      out_item_t   want;
      c = it.text_byte;
      chars++;
      if (!int_closed) begin
        if (!lead_done && (c == CHAR_SPACE || c == CHAR_PLUS || c == CHAR_MINUS)) begin
          if (c != CHAR_SPACE) lead_done = 1'b1;
          if (c == CHAR_MINUS) negative = 1'b1;
        end else begin
          lead_done = 1'b1;
          if (!is_digit(c)) begin
            int_closed = 1'b1;
          end else if (!saturated) begin
            wide = {32'd0, int_part} * 10 + (c - CHAR_ZERO);
            if (wide > 64'h7FFF_FFFF) begin
              int_part  = 32'h7FFF_FFFF;
              saturated = 1'b1;
            end else begin
              int_part = wide[31:0];
            end
          end
        end
      end
      // the separator byte also went through the integer parser above
      if (!sep_seen) begin
        if (c == separator) sep_seen = 1'b1;
      end else if (!frac_closed) begin
        if (!is_digit(c)) begin
          frac_closed = 1'b1;
        end else if (frac_count < FRAC_LIMIT) begin
          frac_digits = frac_digits * 10 + (c - CHAR_ZERO);
          frac_count++;
        end
      end
      if (!it.last_byte) return;
      q = '0;
      if (frac_count != 0) begin
        scale = 64'd1;
        for (int i = 0; i < frac_count; i++) scale = scale * 10;
        num = {36'd0, frac_digits} << FRAC_BITS;
        num = num / {32'd0, scale};
        q = num[31:0];
      end
      mag = {int_part, q};
      if (negative) mag = -mag;
      want.value          = mag;
      want.overflow       = saturated;
      want.separator_seen = sep_seen;
      if (saturated) saturations++;
      due_numbers.push_back(want);
      clear();
    endfunction

    function void check_number(out_item_t got);
      out_item_t want;
      if (due_numbers.size() == 0) begin
        $error("result with nothing due: value %h", got.value);
        errors++;
        return;
      end
      want = due_numbers.pop_front();
      checked++;
      if (got.value !== want.value) begin
        $error("value expected %h actual %h", want.value, got.value);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow expected %b actual %b", want.overflow, got.overflow);
        errors++;
      end
      if (got.separator_seen !== want.separator_seen) begin
        $error("separator_seen expected %b actual %b", want.separator_seen,
               got.separator_seen);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_write;
  logic [7:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  number_scoreboard numbers = new();
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int cycles = 0;

  decimal_text_to_fixed_point #(
    .FRAC_DIGITS(FRAC_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic text_q_t from_ascii(string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // spaces, sign, integer digits, separator, fraction digits, maybe a tail
  function automatic text_q_t well_formed(logic [7:0] sep);
    text_q_t t;
    int      n;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) t.push_back(CHAR_SPACE);
    case ($urandom_range(0, 3))
      0: t.push_back(CHAR_MINUS);
      1: t.push_back(CHAR_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        t = {t, from_ascii($sformatf("%0d", longint'(32'h7FFF_FFFF) + $urandom_range(0, 1)))};
      end else begin
        t.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
        repeat ($urandom_range(9, 11)) t.push_back(rand_digit());
      end
    end else begin
      repeat ($urandom_range(0, 5)) t.push_back(rand_digit());
    end
    if ($urandom_range(0, 4) != 0) begin
      t.push_back(sep);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
      repeat (n) t.push_back(rand_digit());
    end
    if ($urandom_range(0, 3) == 0) t.push_back(8'($urandom_range(0, 255)));
    if (t.size() == 0) t.push_back(rand_digit());
    return t;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    numbers.take_char(it);
    @(negedge clk);
  endtask

  task automatic send_number(input text_q_t t);
    in_item_t it;
    for (int i = 0; i < t.size(); i++) begin
      it.text_byte = t[i];
      it.last_byte = (i == t.size() - 1);
      send_item(it);
    end
  endtask

  // called at a falling edge with the sender quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (numbers.due_numbers.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_separator(input logic [7:0] sep);
    cfg_write <= 1'b1;
    cfg_data  <= sep;
    @(negedge clk);
    cfg_write <= 1'b0;
    numbers.separator = sep;
  endtask

  // random part of one separator setting
  task automatic run_phase();
    int      start;
    text_q_t t;
    start = numbers.chars;
    while (numbers.chars - start < PHASE_CHARS) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          t = {};
          repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
        end
        2, 3: begin
          t = well_formed(numbers.separator);
          t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
        end
        default: t = well_formed(numbers.separator);
      endcase
      send_number(t);
    end
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 12);
      if (!held && numbers.checked == HOLD_AT) begin
        held = 1'b1;
        gap  = gap + HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      numbers.check_number(out_item);
      @(negedge clk);
    end
  end

  initial begin
    text_q_t t;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // negative zero after a leading space
    send_number(from_ascii(" -0"));
    // integer part saturates, no separator
    send_number(from_ascii("9999999999"));
    // no integer digits, extra fraction digits, top byte value closes it
    t = from_ascii(".0123456789");
    t.push_back(8'hFF);
    send_number(t);
    // byte zero alone
    t = {8'h00};
    send_number(t);
    // sign right after the separator: no fraction
    send_number(from_ascii("1.-"));

    run_phase();
    for (int s = 0; s < SETTINGS_NUM; s++) begin
      drain();
      write_separator(SEPARATORS[s]);
      run_phase();
    end
    in_valid <= 1'b0;
    while (numbers.due_numbers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (numbers.due_numbers.size() != 0) begin
      $error("%0d numbers never came out", numbers.due_numbers.size());
      numbers.errors++;
    end

    $display("Sent %0d characters under %0d separator settings; %0d numbers checked,",
             numbers.chars, SETTINGS_NUM + 1, numbers.checked);
    $display("%0d with a saturated integer part, one long output stall included.",
             numbers.saturations);
    if (numbers.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
